FILE: src/ndefd_pkg.sv
// Shared types and constants for the NDEF record deframer.
package ndefd_pkg;

    localparam logic [7:0] FLAG_MB  = 8'h80;
    localparam logic [7:0] FLAG_ME  = 8'h40;
    localparam logic [7:0] FLAG_CF  = 8'h20;
    localparam logic [7:0] FLAG_SR  = 8'h10;
    localparam logic [7:0] FLAG_IL  = 8'h08;
    localparam logic [7:0] TNF_MASK = 8'h07;

    localparam logic [2:0] KIND_FLAGS   = 3'd0;
    localparam logic [2:0] KIND_TYPELEN = 3'd1;
    localparam logic [2:0] KIND_PAYLEN  = 3'd2;
    localparam logic [2:0] KIND_IDLEN   = 3'd3;
    localparam logic [2:0] KIND_TYPE    = 3'd4;
    localparam logic [2:0] KIND_ID      = 3'd5;
    localparam logic [2:0] KIND_PAYLOAD = 3'd6;

    localparam logic [1:0] LEN_LAST_INDEX = 2'd3;

    typedef enum logic [6:0] {
        PH_FLAGS   = 7'b0000001,
        PH_TYPELEN = 7'b0000010,
        PH_PAYLEN  = 7'b0000100,
        PH_IDLEN   = 7'b0001000,
        PH_TYPE    = 7'b0010000,
        PH_ID      = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        AFTER_HEADER  = 2'd0,
        AFTER_TYPE    = 2'd1,
        AFTER_ID      = 2'd2,
        AFTER_PAYLOAD = 2'd3
    } section_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_of_buffer;
    } stage_t;

    typedef struct packed {
        phase_t phase;
        logic   advance;
    } status_t;

endpackage

FILE: src/ndefd_in_if.sv
// Input channel: one message byte with its end-of-buffer mark.
interface ndefd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_buffer;

    modport source (output valid, output data_byte, output last_of_buffer, input ready);
    modport sink (input valid, input data_byte, input last_of_buffer, output ready);
endinterface

FILE: src/ndefd_out_if.sv
// Output channel: byte role, byte and decoded record header fields.
interface ndefd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_kind;
    logic [7:0]  byte_out;
    logic [2:0]  name_format;
    logic        message_begin;
    logic        message_end;
    logic        chunk_flag;
    logic        short_record;
    logic        id_present;
    logic [7:0]  type_length_out;
    logic [31:0] payload_length_out;
    logic        record_done;
    logic        malformed;

    modport source (
        output valid, input ready,
        output byte_kind, output byte_out, output name_format,
        output message_begin, output message_end, output chunk_flag,
        output short_record, output id_present, output type_length_out,
        output payload_length_out, output record_done, output malformed
    );
    modport sink (
        input valid, output ready,
        input byte_kind, input byte_out, input name_format,
        input message_begin, input message_end, input chunk_flag,
        input short_record, input id_present, input type_length_out,
        input payload_length_out, input record_done, input malformed
    );
endinterface

FILE: src/ndef_record_deframer_unit.sv
// Top level of the NDEF record deframer: input register, parser and result register.
// Path: a byte transaction accepted into the input register moves on to the result
// register once that register is free (two register stages, input and result).
// Throughput: one byte per cycle while out_ch.ready does not hold the result register.
// Reset (rst_n low, asynchronous): both stages empty, phase at the flag byte,
// all header fields and counters cleared.
module ndef_record_deframer_unit (
    input  logic         clk,
    input  logic         rst_n,
    ndefd_in_if.sink     in_ch,
    ndefd_out_if.source  out_ch
);
    import ndefd_pkg::*;

    stage_t  stage;
    status_t status;

    ndefd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (status.advance),
        .stage   (stage)
    );

    ndefd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .out_ch (out_ch),
        .status (status)
    );

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(status.phase))
        else $error("parse phase not one-hot");

    a_done_xor_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.record_done && out_ch.malformed))
        else $error("record done and malformed together");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("input taken while both stages are held");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        status.advance |=> out_ch.valid)
        else $error("advanced byte did not reach the result register");

endmodule

FILE: src/ndefd_in_stage.sv
// Input register that captures one byte transaction ahead of the parser.
module ndefd_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    ndefd_in_if.sink        in_ch,
    input  logic            advance,
    output ndefd_pkg::stage_t stage
);
    import ndefd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       take;

    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_ch.data_byte;
            last_reg <= in_ch.last_of_buffer;
        end
    end

    assign stage.valid          = valid_reg;
    assign stage.data_byte      = byte_reg;
    assign stage.last_of_buffer = last_reg;

endmodule

FILE: src/ndefd_parser.sv
// Record phase machine, header field registers and result register.
module ndefd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  ndefd_pkg::stage_t stage,
    ndefd_out_if.source       out_ch,
    output ndefd_pkg::status_t status
);
    import ndefd_pkg::*;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] remaining;
        logic        done;
    } next_sec_t;

    phase_t      phase_reg,  phase_next;
    logic [31:0] rem_reg,    rem_next;
    logic [7:0]  flags_reg,  flags_next;
    logic [7:0]  tlen_reg,   tlen_next;
    logic [7:0]  ilen_reg,   ilen_next;
    logic [31:0] plen_reg,   plen_next;
    logic [1:0]  idx_reg,    idx_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  oflags_reg;
    logic [7:0]  otlen_reg;
    logic [31:0] oplen_reg;
    logic        done_reg;
    logic        bad_reg;

    logic        advance;
    logic [7:0]  b;
    logic [2:0]  kind;
    logic        done;
    logic        bad;
    logic        len_finished;
    next_sec_t   sec;

    function automatic next_sec_t pick_section(section_t after, logic [7:0] tl,
                                               logic [7:0] il, logic [31:0] pl);
        next_sec_t r;
        r.phase     = PH_FLAGS;
        r.remaining = 32'd0;
        r.done      = 1'b1;
        if (after == AFTER_HEADER && tl != 8'd0)
        begin
            r.phase     = PH_TYPE;
            r.remaining = {24'd0, tl};
            r.done      = 1'b0;
        end
        else if ((after == AFTER_HEADER || after == AFTER_TYPE) && il != 8'd0)
        begin
            r.phase     = PH_ID;
            r.remaining = {24'd0, il};
            r.done      = 1'b0;
        end
        else if (after != AFTER_PAYLOAD && pl != 32'd0)
        begin
            r.phase     = PH_PAYLOAD;
            r.remaining = pl;
            r.done      = 1'b0;
        end
        return r;
    endfunction

    assign advance = stage.valid && (!out_valid_reg || out_ch.ready);
    assign b       = stage.data_byte;

    always_comb
    begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        flags_next   = flags_reg;
        tlen_next    = tlen_reg;
        ilen_next    = ilen_reg;
        plen_next    = plen_reg;
        idx_next     = idx_reg;
        done         = 1'b0;
        bad          = 1'b0;
        len_finished = 1'b0;
        kind         = KIND_FLAGS;
        sec          = pick_section(AFTER_PAYLOAD, tlen_reg, ilen_reg, plen_reg);

        case (phase_reg)
            PH_TYPELEN:
            begin
                kind       = KIND_TYPELEN;
                tlen_next  = b;
                plen_next  = 32'd0;
                idx_next   = 2'd0;
                phase_next = PH_PAYLEN;
            end
            PH_PAYLEN:
            begin
                kind = KIND_PAYLEN;
                if ((flags_reg & FLAG_SR) != 8'd0)
                begin
                    plen_next    = {24'd0, b};
                    len_finished = 1'b1;
                end
                else
                begin
                    plen_next    = {plen_reg[23:0], b};
                    len_finished = (idx_reg == LEN_LAST_INDEX);
                    idx_next     = idx_reg + 2'd1;
                end
                if (len_finished)
                begin
                    idx_next = 2'd0;
                    if ((flags_reg & FLAG_IL) != 8'd0)
                    begin
                        phase_next = PH_IDLEN;
                    end
                    else
                    begin
                        ilen_next  = 8'd0;
                        sec        = pick_section(AFTER_HEADER, tlen_reg, 8'd0, plen_next);
                        phase_next = sec.phase;
                        rem_next   = sec.remaining;
                        done       = sec.done;
                    end
                end
            end
            PH_IDLEN:
            begin
                kind       = KIND_IDLEN;
                ilen_next  = b;
                sec        = pick_section(AFTER_HEADER, tlen_reg, b, plen_reg);
                phase_next = sec.phase;
                rem_next   = sec.remaining;
                done       = sec.done;
            end
            PH_TYPE, PH_ID, PH_PAYLOAD:
            begin
                if (phase_reg == PH_TYPE)
                begin
                    kind = KIND_TYPE;
                    sec  = pick_section(AFTER_TYPE, tlen_reg, ilen_reg, plen_reg);
                end
                else if (phase_reg == PH_ID)
                begin
                    kind = KIND_ID;
                    sec  = pick_section(AFTER_ID, tlen_reg, ilen_reg, plen_reg);
                end
                else
                begin
                    kind = KIND_PAYLOAD;
                end
                if (rem_reg <= 32'd1)
                begin
                    phase_next = sec.phase;
                    rem_next   = sec.remaining;
                    done       = sec.done;
                end
                else
                begin
                    rem_next = rem_reg - 32'd1;
                end
            end
            default:
            begin
                kind       = KIND_FLAGS;
                flags_next = b;
                tlen_next  = 8'd0;
                ilen_next  = 8'd0;
                plen_next  = 32'd0;
                idx_next   = 2'd0;
                rem_next   = 32'd0;
                phase_next = PH_TYPELEN;
            end
        endcase

        if (stage.last_of_buffer && !done)
        begin
            bad        = 1'b1;
            phase_next = PH_FLAGS;
            rem_next   = 32'd0;
            idx_next   = 2'd0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAGS;
            rem_reg       <= 32'd0;
            flags_reg     <= 8'd0;
            tlen_reg      <= 8'd0;
            ilen_reg      <= 8'd0;
            plen_reg      <= 32'd0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
                flags_reg <= flags_next;
                tlen_reg  <= tlen_next;
                ilen_reg  <= ilen_next;
                plen_reg  <= plen_next;
                idx_reg   <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg   <= kind;
            byte_reg   <= b;
            oflags_reg <= flags_next;
            otlen_reg  <= tlen_next;
            oplen_reg  <= plen_next;
            done_reg   <= done;
            bad_reg    <= bad;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.byte_kind          = kind_reg;
    assign out_ch.byte_out           = byte_reg;
    assign out_ch.name_format        = oflags_reg[2:0];
    assign out_ch.message_begin      = oflags_reg[7];
    assign out_ch.message_end        = oflags_reg[6];
    assign out_ch.chunk_flag         = oflags_reg[5];
    assign out_ch.short_record       = oflags_reg[4];
    assign out_ch.id_present         = oflags_reg[3];
    assign out_ch.type_length_out    = otlen_reg;
    assign out_ch.payload_length_out = oplen_reg;
    assign out_ch.record_done        = done_reg;
    assign out_ch.malformed          = bad_reg;

    assign status.phase   = phase_reg;
    assign status.advance = advance;

endmodule
